FILE: rtl/core/lr_pkg.sv
// Shared types and widths for the line rasteriser.
`timescale 1ns / 1ps

package lr_pkg;

	localparam int COORD_BITS = 10;
	localparam int COLOR_BITS = 16;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [COLOR_BITS-1:0] color_t;
	typedef logic signed [COORD_BITS:0] err_t;

	typedef struct packed {
		logic   busy;
		logic   steep;
		coord_t major_pos;
		coord_t major_end;
		coord_t minor_pos;
		logic   minor_down;
		coord_t major_delta;
		coord_t minor_delta;
		err_t   step_error;
		color_t color;
	} line_state_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		color_t color;
		logic   last;
	} pixel_t;

endpackage

FILE: rtl/core/lr_setup.sv
// Start-of-line setup: steepness, axis swap, endpoint ordering and initial error.
`timescale 1ns / 1ps

module lr_setup (
	input  lr_pkg::coord_t      start_x,
	input  lr_pkg::coord_t      start_y,
	input  lr_pkg::coord_t      end_x,
	input  lr_pkg::coord_t      end_y,
	input  lr_pkg::color_t      line_color,
	output lr_pkg::line_state_t setup_state
);
	import lr_pkg::*;

	coord_t dx, dy;
	logic   steep;
	coord_t a1, b1, a2, b2;
	coord_t lo_a, lo_b, hi_a, hi_b;

	always_comb begin
		dx    = (start_x > end_x) ? (start_x - end_x) : (end_x - start_x);
		dy    = (start_y > end_y) ? (start_y - end_y) : (end_y - start_y);
		steep = (dy > dx);

		if (steep) begin
			a1 = start_y; b1 = start_x; a2 = end_y; b2 = end_x;
		end else begin
			a1 = start_x; b1 = start_y; a2 = end_x; b2 = end_y;
		end

		// order so that the major coordinate grows
		if (a1 > a2) begin
			lo_a = a2; lo_b = b2; hi_a = a1; hi_b = b1;
		end else begin
			lo_a = a1; lo_b = b1; hi_a = a2; hi_b = b2;
		end

		setup_state.busy        = 1'b1;
		setup_state.steep       = steep;
		setup_state.major_pos   = lo_a;
		setup_state.major_end   = hi_a;
		setup_state.minor_pos   = lo_b;
		setup_state.minor_down  = !(lo_b < hi_b);
		setup_state.major_delta = hi_a - lo_a;
		setup_state.minor_delta = (lo_b > hi_b) ? (lo_b - hi_b) : (hi_b - lo_b);
		setup_state.step_error  = err_t'({1'b0, setup_state.major_delta >> 1});
		setup_state.color       = line_color;
	end

endmodule

FILE: rtl/core/lr_step.sv
// Line state registers and the per-pixel Bresenham step.
`timescale 1ns / 1ps

module lr_step (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic                start,
	input  lr_pkg::line_state_t setup_state,
	output logic                emit,
	output lr_pkg::pixel_t      pixel,
	output logic                busy
);
	import lr_pkg::*;

	line_state_t state_q;
	line_state_t cur;
	line_state_t nxt;
	logic signed [COORD_BITS+1:0] err_sub;
	logic signed [COORD_BITS+1:0] err_add;
	logic last;

	always_comb begin
		cur  = start ? setup_state : state_q;
		emit = start || state_q.busy;
		last = (cur.major_pos == cur.major_end);

		pixel.x     = cur.steep ? cur.minor_pos : cur.major_pos;
		pixel.y     = cur.steep ? cur.major_pos : cur.minor_pos;
		pixel.color = cur.color;
		pixel.last  = last;

		err_sub = $signed({cur.step_error[COORD_BITS], cur.step_error})
			- $signed({2'b00, cur.minor_delta});
		err_add = err_sub + $signed({2'b00, cur.major_delta});

		nxt = cur;
		if (err_sub[COORD_BITS+1]) begin
			nxt.step_error = err_add[COORD_BITS:0];
			nxt.minor_pos  = cur.minor_down ? (cur.minor_pos - coord_t'(1))
				: (cur.minor_pos + coord_t'(1));
		end else begin
			nxt.step_error = err_sub[COORD_BITS:0];
		end
		nxt.busy = !last;
		if (!last) nxt.major_pos = cur.major_pos + coord_t'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance && emit) begin
			state_q <= nxt;
		end
	end

	assign busy = state_q.busy;

endmodule

FILE: rtl/core/line_rasterizer.sv
// Top level of the Bresenham line rasteriser: input register, step logic, output register.
`timescale 1ns / 1ps

// Integer Bresenham line rasteriser. A transaction with action 0 starts a line from the two
// endpoints and colour and emits its first pixel; each transaction with action 1 emits the next
// pixel, and the pixel at the far end of the major axis carries last_pixel. A step with no line
// running produces nothing; a start while a line runs abandons it. One transaction is accepted
// every cycle while the consumer keeps up; the transaction sits in the input register while the
// setup and step logic loads its pixel into the output register, which holds a pixel while
// the consumer stalls and still lets the next transaction in.
module line_rasterizer (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           action,
	input  lr_pkg::coord_t start_x,
	input  lr_pkg::coord_t start_y,
	input  lr_pkg::coord_t end_x,
	input  lr_pkg::coord_t end_y,
	input  lr_pkg::color_t line_color,
	output logic           out_valid,
	input  logic           out_ready,
	output lr_pkg::coord_t pixel_x,
	output lr_pkg::coord_t pixel_y,
	output lr_pkg::color_t pixel_color,
	output logic           last_pixel
);
	import lr_pkg::*;

	logic        valid_s1;
	logic        action_s1;
	coord_t      start_x_s1, start_y_s1, end_x_s1, end_y_s1;
	color_t      color_s1;
	logic        advance;
	logic        emit;
	logic        busy;
	line_state_t setup_state;
	pixel_t      pixel;
	pixel_t      pixel_q;
	logic        out_valid_q;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			action_s1  <= action;
			start_x_s1 <= start_x;
			start_y_s1 <= start_y;
			end_x_s1   <= end_x;
			end_y_s1   <= end_y;
			color_s1   <= line_color;
		end
	end

	lr_setup u_setup (
		.start_x     (start_x_s1),
		.start_y     (start_y_s1),
		.end_x       (end_x_s1),
		.end_y       (end_y_s1),
		.line_color  (color_s1),
		.setup_state (setup_state)
	);

	lr_step u_step (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.start       (!action_s1),
		.setup_state (setup_state),
		.emit        (emit),
		.pixel       (pixel),
		.busy        (busy)
	);

	// drop the held pixel once taken, load a new one when the step emits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			pixel_q <= pixel;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_x     = pixel_q.x;
	assign pixel_y     = pixel_q.y;
	assign pixel_color = pixel_q.color;
	assign last_pixel  = pixel_q.last;

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s1)
		else $error("accepted transaction did not reach the input register");

	a_start_emits: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !action_s1 |=> out_valid)
		else $error("start transaction produced no pixel");

	a_idle_step_silent: assert property (@(posedge clk) disable iff (!arst_n)
		advance && action_s1 && !busy |=> !out_valid)
		else $error("step while idle produced a pixel");

	a_last_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		advance && emit && pixel.last |=> !busy)
		else $error("line still running after its last pixel");

	a_not_last_stays_busy: assert property (@(posedge clk) disable iff (!arst_n)
		advance && emit && !pixel.last |=> busy)
		else $error("line stopped before its last pixel");

endmodule

FILE: bench/line_rasterizer_tb.sv
// Self-checking testbench for the line rasteriser: directed table, then random lines.
`timescale 1ns / 1ps

module line_rasterizer_tb;

	import lr_pkg::*;

	typedef enum logic {
		ACT_START = 1'b0,
		ACT_STEP  = 1'b1
	} action_e;

	typedef struct packed {
		coord_t x;
		coord_t y;
		color_t color;
		logic   last;
	} pixel_s;

	typedef struct {
		action_e act;
		coord_t  sx;
		coord_t  sy;
		coord_t  ex;
		coord_t  ey;
		color_t  col;
		bit      typed;
		bit      hit;
		pixel_s  pix;
	} plan_row_s;

	localparam pixel_s NO_PIX        = '0;
	localparam int     DIRECTED_ROWS = 22;
	localparam int     ITEM_BUDGET   = 2000;

	logic   clk;
	logic   arst_n;
	logic   in_valid;
	logic   in_ready;
	logic   action;
	coord_t start_x;
	coord_t start_y;
	coord_t end_x;
	coord_t end_y;
	color_t line_color;
	logic   out_valid;
	logic   out_ready;
	coord_t pixel_x;
	coord_t pixel_y;
	color_t pixel_color;
	logic   last_pixel;

	// predicted line state
	bit     line_busy  = 1'b0;
	bit     line_steep = 1'b0;
	coord_t maj_pos    = '0;
	coord_t maj_end    = '0;
	coord_t min_pos    = '0;
	bit     min_down   = 1'b0;
	coord_t maj_delta  = '0;
	coord_t min_delta  = '0;
	int     line_err   = 0;
	color_t line_hue   = '0;

	pixel_s pending_pixels[$];
	int     mismatch_count = 0;
	int     items_sent     = 0;
	bit     calm           = 1'b0;

	plan_row_s directed_plan [DIRECTED_ROWS] = '{
		'{ACT_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    16'h0000, 1'b1, 1'b0, NO_PIX},
		'{ACT_START, 10'd0,    10'd0,    10'd0,    10'd0,    16'h0000, 1'b1, 1'b1,
			'{10'd0, 10'd0, 16'h0000, 1'b1}},
		'{ACT_START, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 16'hFFFF, 1'b1, 1'b1,
			'{10'd1023, 10'd1023, 16'hFFFF, 1'b1}},
		'{ACT_STEP,  10'd1023, 10'd1023, 10'd1023, 10'd1023, 16'hFFFF, 1'b1, 1'b0, NO_PIX},
		'{ACT_START, 10'd0,    10'd5,    10'd3,    10'd5,    16'h1234, 1'b1, 1'b1,
			'{10'd0, 10'd5, 16'h1234, 1'b0}},
		'{ACT_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    16'h0000, 1'b1, 1'b1,
			'{10'd1, 10'd5, 16'h1234, 1'b0}},
		'{ACT_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    16'h0000, 1'b1, 1'b1,
			'{10'd2, 10'd5, 16'h1234, 1'b0}},
		'{ACT_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    16'h0000, 1'b1, 1'b1,
			'{10'd3, 10'd5, 16'h1234, 1'b1}},
		'{ACT_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    16'h0000, 1'b1, 1'b0, NO_PIX},
		'{ACT_START, 10'd7,    10'd9,    10'd4,    10'd1,    16'h0F0F, 1'b0, 1'b0, NO_PIX},
		'{ACT_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    16'h0000, 1'b0, 1'b0, NO_PIX},
		'{ACT_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    16'h0000, 1'b0, 1'b0, NO_PIX},
		'{ACT_START, 10'd0,    10'd0,    10'd1023, 10'd1023, 16'hAAAA, 1'b1, 1'b1,
			'{10'd0, 10'd0, 16'hAAAA, 1'b0}},
		'{ACT_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    16'h0000, 1'b0, 1'b0, NO_PIX},
		'{ACT_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    16'h0000, 1'b0, 1'b0, NO_PIX},
		'{ACT_START, 10'd1023, 10'd0,    10'd0,    10'd1023, 16'h5555, 1'b0, 1'b0, NO_PIX},
		'{ACT_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    16'h0000, 1'b0, 1'b0, NO_PIX},
		'{ACT_START, 10'd0,    10'd1023, 10'd1,    10'd0,    16'h8001, 1'b0, 1'b0, NO_PIX},
		'{ACT_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    16'h0000, 1'b0, 1'b0, NO_PIX},
		'{ACT_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    16'h0000, 1'b0, 1'b0, NO_PIX},
		'{ACT_START, 10'd512,  10'd300,  10'd512,  10'd900,  16'h7FFF, 1'b0, 1'b0, NO_PIX},
		'{ACT_STEP,  10'd0,    10'd0,    10'd0,    10'd0,    16'h0000, 1'b0, 1'b0, NO_PIX}
	};

	line_rasterizer u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.start_x     (start_x),
		.start_y     (start_y),
		.end_x       (end_x),
		.end_y       (end_y),
		.line_color  (line_color),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_color (pixel_color),
		.last_pixel  (last_pixel)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

	task automatic note_mismatch(input string msg);
		$display("mismatch: %s", msg);
		mismatch_count++;
	endtask

	// Advance the predicted line by one transaction; returns 1 when a pixel is due.
	function automatic bit next_pixel(input action_e act, input coord_t sx, input coord_t sy,
			input coord_t ex, input coord_t ey, input color_t col, output pixel_s px);
		coord_t a1, b1, a2, b2, t;
		bit     is_last;
		px = NO_PIX;
		if (act == ACT_START) begin
			line_steep = (sy > ey ? sy - ey : ey - sy) > (sx > ex ? sx - ex : ex - sx);
			if (line_steep) begin
				a1 = sy; b1 = sx; a2 = ey; b2 = ex;
			end else begin
				a1 = sx; b1 = sy; a2 = ex; b2 = ey;
			end
			if (a1 > a2) begin
				t = a1; a1 = a2; a2 = t;
				t = b1; b1 = b2; b2 = t;
			end
			maj_pos   = a1;
			maj_end   = a2;
			min_pos   = b1;
			min_down  = !(b1 < b2);
			maj_delta = a2 - a1;
			min_delta = (b1 > b2) ? b1 - b2 : b2 - b1;
			line_err  = int'(maj_delta >> 1);
			line_hue  = col;
		end else if (!line_busy) begin
			return 1'b0;
		end
		is_last  = (maj_pos == maj_end);
		px.x     = line_steep ? min_pos : maj_pos;
		px.y     = line_steep ? maj_pos : min_pos;
		px.color = line_hue;
		px.last  = is_last;
		line_err -= int'(min_delta);
		if (line_err < 0) begin
			min_pos  = min_down ? min_pos - 1'b1 : min_pos + 1'b1;
			line_err += int'(maj_delta);
		end
		if (is_last) begin
			line_busy = 1'b0;
		end else begin
			line_busy = 1'b1;
			maj_pos   = maj_pos + 1'b1;
		end
		return 1'b1;
	endfunction

	// Pick a coordinate within span of base, held on screen.
	function automatic coord_t near(input coord_t base, input int span);
		int v;
		v = int'(base) + int'($urandom_range(0, 2 * span)) - span;
		if (v < 0)
			v = 0;
		if (v > 1023)
			v = 1023;
		return coord_t'(v);
	endfunction

	task automatic send_item(input action_e act, input coord_t sx, input coord_t sy,
			input coord_t ex, input coord_t ey, input color_t col,
			input bit typed, input bit typed_hit, input pixel_s typed_pix);
		pixel_s px;
		bit     hit;
		int     gap;
		action     <= act;
		start_x    <= sx;
		start_y    <= sy;
		end_x      <= ex;
		end_y      <= ey;
		line_color <= col;
		in_valid   <= 1'b1;
		do @(posedge clk); while (in_ready !== 1'b1);
		items_sent++;
		hit = next_pixel(act, sx, sy, ex, ey, col, px);
		if (typed) begin
			hit = typed_hit;
			px  = typed_pix;
		end
		if (hit) begin
			pending_pixels.push_back(px);
		end
		gap = calm ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_random_step();
		send_item(ACT_STEP, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
			coord_t'($urandom), color_t'($urandom), 1'b0, 1'b0, NO_PIX);
	endtask

	// Pixel sink: random stalls, compare each pixel with the oldest prediction.
	initial begin
		pixel_s want;
		int     stall;
		out_ready <= 1'b0;
		@(posedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 9);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
			if (pending_pixels.size() == 0) begin
				note_mismatch($sformatf("unexpected pixel (%0d,%0d)", pixel_x, pixel_y));
			end else begin
				want = pending_pixels.pop_front();
				if (pixel_x !== want.x)
					note_mismatch($sformatf("pixel_x %0d, want %0d", pixel_x, want.x));
				if (pixel_y !== want.y)
					note_mismatch($sformatf("pixel_y %0d, want %0d", pixel_y, want.y));
				if (pixel_color !== want.color)
					note_mismatch($sformatf("pixel_color %h, want %h", pixel_color, want.color));
				if (last_pixel !== want.last)
					note_mismatch($sformatf("last_pixel %b, want %b", last_pixel, want.last));
			end
		end
	end

	initial begin
		coord_t sx, sy;
		int     span;
		int     cut;
		int     steps;
		bit     drained;
		drained    = 1'b0;
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		action     <= ACT_START;
		start_x    <= '0;
		start_y    <= '0;
		end_x      <= '0;
		end_y      <= '0;
		line_color <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_plan[i])
			send_item(directed_plan[i].act, directed_plan[i].sx, directed_plan[i].sy,
				directed_plan[i].ex, directed_plan[i].ey, directed_plan[i].col,
				directed_plan[i].typed, directed_plan[i].hit, directed_plan[i].pix);

		while (items_sent < ITEM_BUDGET) begin
			// hold off once, mid-run, until every pixel has drained
			if (!drained && items_sent >= ITEM_BUDGET / 2) begin
				in_valid <= 1'b0;
				while (pending_pixels.size() != 0)
					@(posedge clk);
				drained = 1'b1;
			end
			if ($urandom_range(0, 29) == 0)
				calm = !calm;
			if ($urandom_range(0, 9) == 0) begin
				send_random_step();
			end else begin
				span = ($urandom_range(0, 99) == 0) ? 1023 : $urandom_range(0, 15);
				sx   = coord_t'($urandom_range(0, 1023));
				sy   = coord_t'($urandom_range(0, 1023));
				send_item(ACT_START, sx, sy, near(sx, span), near(sy, span),
					color_t'($urandom), 1'b0, 1'b0, NO_PIX);
				// now and then abandon the line early with a fresh start
				cut   = ($urandom_range(0, 4) == 0) ? $urandom_range(0, span) : -1;
				steps = 0;
				while (line_busy && items_sent < ITEM_BUDGET && steps != cut) begin
					send_random_step();
					steps++;
				end
			end
		end

		in_valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

FILE: line_rasterizer.f
rtl/core/lr_pkg.sv
rtl/core/lr_setup.sv
rtl/core/lr_step.sv
rtl/core/line_rasterizer.sv
bench/line_rasterizer_tb.sv
